// ===== rtl/core/stis_pkg.sv =====
// Shared types and constants for the sorted table core.
// Holds the table size, field widths, request and status codes, the item structs
// and the sequencer state type. Depends on nothing.
package stis_pkg;

    // Table size and derived widths
    localparam int unsigned CAPACITY = 16;
    localparam int unsigned ADDR_W   = $clog2(CAPACITY);
    localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the items
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned STAT_W   = 3;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned COUNT_W  = 5;

    // Width for comparing the delete position with the fill level
    localparam int unsigned CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // Request kinds
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         index;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/core/sorted_table_insert_delete_search_core.sv =====
// Top level of the sorted table core: sequencer, shared comparator and result register.
// Depends on stis_pkg and the stis_ram table memory.
//
// Usage:
//   The req channel takes one item (mode, value, index) at a time; the rsp
//   channel returns one item (status, position, count) for every request.
//   Both are valid/ready channels; an item moves when valid and ready are high.
//   The table keeps signed values in ascending order in a RAM of CAPACITY
//   entries. One comparator is shared by insert and search, which walk the
//   table one entry per cycle; insert and delete then move entries one per
//   cycle through the RAM's single write port.
//   The table walk over the RAM read port sets how long a request takes;
//   rejected or unused requests go straight from decision to the result step.
//   req_ready is high only while the sequencer is idle.
//   A finished result waits in the rsp register; the next request is taken
//   while it waits, and that request holds in its last step until the
//   receiver takes the earlier result.
//   Reset empties the table (fill level zero) and drops any pending result.
module sorted_table_insert_delete_search_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  stis_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output stis_pkg::rsp_t rsp
);

    // Sequencer and table state
    stis_pkg::state_t state_reg, state_next;
    logic [stis_pkg::CNT_W-1:0] ptr_reg, ptr_next;
    logic [stis_pkg::CNT_W-1:0] pos_reg, pos_next;
    logic [stis_pkg::CNT_W-1:0] fill_reg, fill_next;
    logic [stis_pkg::STAT_W-1:0] status_reg, status_next;

    // Held request
    stis_pkg::req_t op_reg, op_next;

    // Result register
    stis_pkg::rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg, rsp_valid_next;

    // Table memory port
    logic                        ram_we;
    logic [stis_pkg::ADDR_W-1:0] ram_waddr;
    logic [stis_pkg::DATA_W-1:0] ram_wdata;
    logic [stis_pkg::ADDR_W-1:0] ram_raddr;
    logic [stis_pkg::DATA_W-1:0] ram_rdata;

    // Shared comparator
    logic entry_lt;
    logic entry_eq;
    logic at_end;
    logic stop_ins;

    stis_ram #(
        .WIDTH (stis_pkg::DATA_W),
        .DEPTH (stis_pkg::CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Compare the entry just read against the held value
    assign entry_lt = $signed(ram_rdata) < op_reg.value;
    assign entry_eq = ram_rdata == op_reg.value;
    assign at_end   = ptr_reg == fill_reg;
    assign stop_ins = (op_reg.mode == stis_pkg::MODE_INSERT) && (at_end || !entry_lt);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stis_pkg::ST_IDLE;
            ptr_reg       <= '0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            status_reg    <= stis_pkg::STAT_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        status_next    = status_reg;
        op_next        = op_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ram_we         = 1'b0;
        ram_waddr      = stis_pkg::ADDR_W'(ptr_reg);
        ram_wdata      = ram_rdata;
        ram_raddr      = '0;
        req_ready      = 1'b0;

        unique case (state_reg)
            stis_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next    = req;
                    state_next = stis_pkg::ST_START;
                end
            end

            stis_pkg::ST_START:
            begin
                // Decide the request; reject early where the table state allows it
                status_next = stis_pkg::STAT_OK;
                pos_next    = '0;
                state_next  = stis_pkg::ST_FINISH;
                case (op_reg.mode)
                    stis_pkg::MODE_INSERT:
                    begin
                        if (fill_reg == stis_pkg::CNT_W'(stis_pkg::CAPACITY))
                        begin
                            status_next = stis_pkg::STAT_FULL;
                        end
                        else
                        begin
                            ptr_next   = '0;
                            state_next = stis_pkg::ST_SCAN;
                        end
                    end
                    stis_pkg::MODE_DELETE:
                    begin
                        if (fill_reg == '0)
                        begin
                            status_next = stis_pkg::STAT_EMPTY;
                        end
                        else if (stis_pkg::CMP_W'(op_reg.index) >=
                                 stis_pkg::CMP_W'(fill_reg))
                        begin
                            status_next = stis_pkg::STAT_RANGE;
                        end
                        else
                        begin
                            // Fetch the entry that moves down into the gap
                            ram_raddr  = stis_pkg::ADDR_W'(stis_pkg::CMP_W'(op_reg.index) +
                                                           stis_pkg::CMP_W'(1));
                            ptr_next   = stis_pkg::CNT_W'(op_reg.index);
                            state_next = stis_pkg::ST_SHIFT_DN;
                        end
                    end
                    stis_pkg::MODE_SEARCH:
                    begin
                        ptr_next   = '0;
                        state_next = stis_pkg::ST_SCAN;
                    end
                    default:
                    begin
                        // Unused request kind: answer ok, leave the table alone
                        status_next = stis_pkg::STAT_OK;
                    end
                endcase
            end

            stis_pkg::ST_SCAN:
            begin
                // ram_rdata holds entry[ptr_reg] when ptr_reg is below the fill level
                if (stop_ins)
                begin
                    pos_next   = ptr_reg;
                    ptr_next   = fill_reg;
                    ram_raddr  = stis_pkg::ADDR_W'(fill_reg - stis_pkg::CNT_W'(1));
                    state_next = stis_pkg::ST_SHIFT_UP;
                end
                else if (at_end)
                begin
                    status_next = stis_pkg::STAT_NOTFOUND;
                    pos_next    = '0;
                    state_next  = stis_pkg::ST_FINISH;
                end
                else if (op_reg.mode == stis_pkg::MODE_SEARCH && entry_eq)
                begin
                    pos_next   = ptr_reg;
                    state_next = stis_pkg::ST_FINISH;
                end
                else
                begin
                    ptr_next  = ptr_reg + stis_pkg::CNT_W'(1);
                    ram_raddr = stis_pkg::ADDR_W'(ptr_reg + stis_pkg::CNT_W'(1));
                end
            end

            stis_pkg::ST_SHIFT_UP:
            begin
                // Move entries up one place from the top, then drop the value in
                ram_we = 1'b1;
                if (ptr_reg == pos_reg)
                begin
                    ram_wdata  = op_reg.value;
                    fill_next  = fill_reg + stis_pkg::CNT_W'(1);
                    state_next = stis_pkg::ST_FINISH;
                end
                else
                begin
                    ram_wdata = ram_rdata;
                    ram_raddr = stis_pkg::ADDR_W'(ptr_reg - stis_pkg::CNT_W'(2));
                    ptr_next  = ptr_reg - stis_pkg::CNT_W'(1);
                end
            end

            stis_pkg::ST_SHIFT_DN:
            begin
                // Close the gap one entry at a time
                if (ptr_reg + stis_pkg::CNT_W'(1) == fill_reg)
                begin
                    fill_next  = fill_reg - stis_pkg::CNT_W'(1);
                    state_next = stis_pkg::ST_FINISH;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    ram_raddr = stis_pkg::ADDR_W'(ptr_reg + stis_pkg::CNT_W'(2));
                    ptr_next  = ptr_reg + stis_pkg::CNT_W'(1);
                end
            end

            stis_pkg::ST_FINISH:
            begin
                // Hold until the result register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status   = status_reg;
                    rsp_next.position = stis_pkg::POS_W'(pos_reg);
                    rsp_next.count    = stis_pkg::COUNT_W'(fill_reg);
                    rsp_valid_next    = 1'b1;
                    state_next        = stis_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = stis_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The fill level never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= stis_pkg::CNT_W'(stis_pkg::CAPACITY))
    else $error("fill level above capacity");

    // The fill level moves by at most one per request step
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(fill_reg) |->
            (fill_reg == $past(fill_reg) + stis_pkg::CNT_W'(1)) ||
            (fill_reg == $past(fill_reg) - stis_pkg::CNT_W'(1)))
    else $error("fill level jumped");

    // The table memory is written only while entries are being moved
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == stis_pkg::ST_SHIFT_UP) ||
                   (state_reg == stis_pkg::ST_SHIFT_DN))
    else $error("table written outside a shift step");

    // A full report always carries a full count
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == stis_pkg::STAT_FULL) |->
            rsp.count == stis_pkg::COUNT_W'(stis_pkg::CAPACITY))
    else $error("full status with table not full");

endmodule

// ===== rtl/core/stis_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters; no dependencies.
module stis_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== test/stis_result_checker.sv =====
// Result checker for the sorted table core: watches both item channels, predicts each result.
// Keeps its own copy of the table and compares every returned item in order.
// Depends on stis_pkg.
module stis_result_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  stis_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  stis_pkg::rsp_t rsp,
    output int             fails,
    output int             pending,
    output int             results,
    output logic [4:0]     status_seen
);

    localparam int PRINT_CAP = 40;

    logic signed [stis_pkg::DATA_W-1:0] table_vals [stis_pkg::CAPACITY];
    int unsigned                        stored;
    stis_pkg::rsp_t                     awaited_rsp [$];
    int                                 mismatch_count;
    int                                 rsp_count;
    logic [4:0]                         codes_hit;

    // Apply one request to the table copy and return the item it should produce
    function automatic stis_pkg::rsp_t apply_request(input stis_pkg::req_t r);
        stis_pkg::rsp_t res;
        int   p;
        int   i;
        logic hit;
        res.status = stis_pkg::STAT_OK;
        p = 0;
        hit = 1'b0;
        case (r.mode)
            stis_pkg::MODE_INSERT:
            begin
                if (stored >= stis_pkg::CAPACITY)
                begin
                    res.status = stis_pkg::STAT_FULL;
                end
                else
                begin
                    while (p < int'(stored) && $signed(table_vals[p]) < $signed(r.value))
                        p++;
                    for (i = int'(stored); i > p; i--)
                        table_vals[i] = table_vals[i-1];
                    table_vals[p] = r.value;
                    stored++;
                end
            end
            stis_pkg::MODE_DELETE:
            begin
                if (stored == 0)
                    res.status = stis_pkg::STAT_EMPTY;
                else if (r.index >= stored)
                    res.status = stis_pkg::STAT_RANGE;
                else
                begin
                    for (i = int'(r.index); i + 1 < int'(stored); i++)
                        table_vals[i] = table_vals[i+1];
                    stored--;
                end
            end
            stis_pkg::MODE_SEARCH:
            begin
                for (i = 0; i < int'(stored) && !hit; i++)
                begin
                    if (table_vals[i] == r.value)
                    begin
                        hit = 1'b1;
                        p = i;
                    end
                end
                if (!hit)
                    res.status = stis_pkg::STAT_NOTFOUND;
            end
            default:
            begin
                // unused request kind: leave the table alone
            end
        endcase
        res.position = p[stis_pkg::POS_W-1:0];
        res.count    = stored[stis_pkg::COUNT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] result %0d: %s mismatch, got %0d, want %0d",
                     $realtime, rsp_count, field, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stis_pkg::rsp_t want;
        if (!rst_n)
        begin
            awaited_rsp.delete();
            stored         = 0;
            mismatch_count = 0;
            rsp_count      = 0;
            codes_hit      = '0;
            fails       <= 0;
            pending     <= 0;
            results     <= 0;
            status_seen <= '0;
        end
        else
        begin
            // results belong to earlier requests, so check before predicting
            if (rsp_valid && rsp_ready)
            begin
                rsp_count++;
                if (awaited_rsp.size() == 0)
                    report_mismatch("unexpected item", 1, 0);
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.position !== want.position)
                        report_mismatch("position", rsp.position, want.position);
                    if (rsp.count !== want.count)
                        report_mismatch("count", rsp.count, want.count);
                end
                if (rsp.status <= stis_pkg::STAT_NOTFOUND)
                    codes_hit[rsp.status] = 1'b1;
            end
            if (req_valid && req_ready)
                awaited_rsp.push_back(apply_request(req));
            fails       <= mismatch_count;
            pending     <= awaited_rsp.size();
            results     <= rsp_count;
            status_seen <= codes_hit;
        end
    end

endmodule

// ===== test/tb_sorted_table_insert_delete_search_core.sv =====
// Testbench top for the sorted table core: clock, reset, request stimulus and verdict.
// Depends on stis_pkg, the core and stis_result_checker, which does all prediction.
module tb_sorted_table_insert_delete_search_core;

    // Request kind the core must ignore
    localparam logic [stis_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 450;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int QUIET_LIMIT  = 3000;  // cycles with no item moving
    localparam int DRAIN_CYCLES = 40;    // beyond the longest request latency
    localparam int HISTORY_MAX  = 32;

    typedef enum int { SEG_GROW, SEG_SHRINK, SEG_MIXED } segment_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    stis_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    stis_pkg::rsp_t rsp;

    int         fails;
    int         pending;
    int         results;
    logic [4:0] status_seen;

    // Stimulus-side bookkeeping: shapes the traffic only, checks nothing
    int          level;
    int          burst_left;
    int          items_sent;
    int          full_hits;
    logic [31:0] history [$];
    bit          squeeze;
    bit          squeezed;
    int          quiet;

    sorted_table_insert_delete_search_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    stis_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .fails       (fails),
        .pending     (pending),
        .results     (results),
        .status_seen (status_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Pack one request item
    function automatic stis_pkg::req_t make_req(input logic [stis_pkg::MODE_W-1:0] m,
                                                input logic [31:0] v,
                                                input logic [stis_pkg::IDX_W-1:0] ix);
        stis_pkg::req_t r;
        r.mode  = m;
        r.value = v;
        r.index = ix;
        return r;
    endfunction

    // Draw a value: reuse earlier inserts for hits and duplicates, crowd small values
    // together, hit the extremes and otherwise spread over the full 32 bits
    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30 && history.size() > 0)
            return history[$urandom_range(0, history.size() - 1)];
        if (roll < 60)
            return 32'($urandom_range(0, 16)) - 32'd8;
        if (roll < 70)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    // Offer one item in the current burst; open a new burst after a random gap.
    // Hold valid and payload until the core takes the item.
    task automatic offer_request(input stis_pkg::req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        items_sent++;
        // track the fill level roughly to steer deletes towards valid positions
        case (r.mode)
            stis_pkg::MODE_INSERT:
            begin
                if (level < stis_pkg::CAPACITY)
                begin
                    level++;
                    history.push_back(r.value);
                    if (history.size() > HISTORY_MAX)
                        void'(history.pop_front());
                end
                else
                    full_hits++;
            end
            stis_pkg::MODE_DELETE:
            begin
                if (level > 0 && r.index < level)
                    level--;
            end
            default:
            begin
            end
        endcase
    endtask

    // Receiver: stretches of steady, patchy and mostly stalled ready, plus one
    // long hold-off so the result register stays full and the core stops taking requests
    initial
    begin
        int kind;
        int span;
        int i;
        squeezed  = 1'b0;
        rsp_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            kind = $urandom_range(0, 2);
            span = $urandom_range(10, 80);
            for (i = 0; i < span; i++)
            begin
                @(posedge clk);
                if (squeeze && !squeezed)
                begin
                    squeezed = 1'b1;
                    rsp_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (kind)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    default: rsp_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Watchdog: end the run if no item moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet <= 0;
        end
        else
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        stis_pkg::req_t directed [$];
        stis_pkg::req_t r;
        segment_t seg;
        int       seg_left;
        int       roll;
        int       n;
        int       n_directed;
        logic [stis_pkg::MODE_W-1:0] m;

        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        req        <= '0;
        level      = 0;
        burst_left = 0;
        items_sent = 0;
        full_hits  = 0;
        squeeze    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-table cases, unused kind, extremes, equal values,
        // search hit and miss, positions out of range, delete first and last
        directed.push_back(make_req(stis_pkg::MODE_SEARCH, 32'd5,         4'd0));
        directed.push_back(make_req(stis_pkg::MODE_DELETE, 32'd0,         4'd0));
        directed.push_back(make_req(MODE_UNUSED,           32'hFFFF_FFFF, 4'd15));
        directed.push_back(make_req(stis_pkg::MODE_INSERT, 32'h7FFF_FFFF, 4'd0));
        directed.push_back(make_req(stis_pkg::MODE_INSERT, 32'h8000_0000, 4'd15));
        directed.push_back(make_req(stis_pkg::MODE_INSERT, 32'h0000_0000, 4'd0));
        directed.push_back(make_req(stis_pkg::MODE_INSERT, 32'h0000_0000, 4'd0));
        directed.push_back(make_req(stis_pkg::MODE_INSERT, 32'hFFFF_FFFF, 4'd0));
        directed.push_back(make_req(stis_pkg::MODE_SEARCH, 32'h0000_0000, 4'd0));
        directed.push_back(make_req(stis_pkg::MODE_SEARCH, 32'h7FFF_FFFF, 4'd0));
        directed.push_back(make_req(stis_pkg::MODE_SEARCH, 32'h8000_0000, 4'd0));
        directed.push_back(make_req(stis_pkg::MODE_SEARCH, 32'd12345,     4'd0));
        directed.push_back(make_req(stis_pkg::MODE_DELETE, 32'd0,         4'd15));
        directed.push_back(make_req(stis_pkg::MODE_DELETE, 32'd0,         4'd5));
        directed.push_back(make_req(MODE_UNUSED,           32'd77,        4'd2));
        directed.push_back(make_req(stis_pkg::MODE_DELETE, 32'd0,         4'd0));
        directed.push_back(make_req(stis_pkg::MODE_DELETE, 32'd0,         4'd3));
        directed.push_back(make_req(stis_pkg::MODE_SEARCH, 32'h7FFF_FFFF, 4'd0));
        foreach (directed[k])
            offer_request(directed[k]);
        n_directed = directed.size();

        // Random: alternate growing, shrinking and mixed stretches so the table
        // swings between empty and full; start with a long growing stretch
        seg      = SEG_GROW;
        seg_left = 60;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (seg_left == 0)
            begin
                seg      = segment_t'($urandom_range(0, 2));
                seg_left = $urandom_range(20, 60);
            end
            seg_left--;
            if (n == RANDOM_ITEMS / 2)
                squeeze = 1'b1;

            roll = $urandom_range(0, 99);
            case (seg)
                SEG_GROW:
                    m = (roll < 70) ? stis_pkg::MODE_INSERT :
                        (roll < 80) ? stis_pkg::MODE_DELETE :
                        (roll < 95) ? stis_pkg::MODE_SEARCH : MODE_UNUSED;
                SEG_SHRINK:
                    m = (roll < 15) ? stis_pkg::MODE_INSERT :
                        (roll < 80) ? stis_pkg::MODE_DELETE :
                        (roll < 95) ? stis_pkg::MODE_SEARCH : MODE_UNUSED;
                default:
                    m = (roll < 35) ? stis_pkg::MODE_INSERT :
                        (roll < 65) ? stis_pkg::MODE_DELETE :
                        (roll < 95) ? stis_pkg::MODE_SEARCH : MODE_UNUSED;
            endcase

            r = make_req(m, pick_value(), 4'($urandom_range(0, 15)));
            // mostly delete a stored position, sometimes one beyond the end
            if (m == stis_pkg::MODE_DELETE && level > 0 && $urandom_range(0, 9) < 8)
                r.index = 4'($urandom_range(0, level - 1));
            offer_request(r);
        end
        req_valid <= 1'b0;

        // Drain: wait for every awaited result, then allow for stray items
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d directed, rest in grow/shrink/mixed stretches),",
                 items_sent, n_directed);
        $display("compared %0d results; status codes seen %b, inserts into a full table %0d.",
                 results, status_seen, full_hits);
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/stis_pkg.sv
rtl/core/stis_ram.sv
rtl/core/sorted_table_insert_delete_search_core.sv
test/stis_result_checker.sv
test/tb_sorted_table_insert_delete_search_core.sv
